>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Sizes, field widths, request codes and the word evaluation record shared
// by the allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_BLOCKS  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_BITS   = $clog2(MAP_WORDS);
   localparam int BIT_BITS    = $clog2(WORD_BITS);
   localparam int INDEX_BITS  = $clog2(MAX_BLOCKS);
   localparam int COUNT_BITS  = $clog2(MAX_BLOCKS + 1);
   localparam int TOTAL_BITS  = 13;
   localparam int FUNC_BITS   = 2;
   localparam int TOTAL_RESET = 4096;
   localparam int FREE_RESET  = (TOTAL_RESET > MAX_BLOCKS) ? MAX_BLOCKS : TOTAL_RESET;

   localparam int REQ_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((INDEX_BITS + COUNT_BITS + 7) / 8) * 8;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_MARK  = 2'd1,
      FUNC_QUERY = 2'd2
   } func_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] eff_word;
      logic [WORD_BITS-1:0] free;
      logic                 any;
      logic [WORD_BITS-1:0] low_onehot;
      logic [BIT_BITS-1:0]  low_index;
      logic [BIT_BITS:0]    zeros;
   } word_eval_type;

endpackage

>>> sv/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bba_word_eval.sv
// ----------------------------------------------------------------------------
// Map word evaluation
// Masks one usage word to the blocks below the limit and finds its lowest
// free block and its number of free blocks.
// ----------------------------------------------------------------------------
module bba_word_eval (
   input  logic [bba_pkg::WORD_BITS-1:0]  word,
   input  logic                           valid,
   input  logic [bba_pkg::ADDR_BITS-1:0]  addr,
   input  logic [bba_pkg::COUNT_BITS-1:0] lim,
   output bba_pkg::word_eval_type         result
);

   logic [bba_pkg::WORD_BITS-1:0]                      eff;
   logic [bba_pkg::WORD_BITS-1:0]                      mask;
   logic [bba_pkg::WORD_BITS-1:0]                      free;
   logic [bba_pkg::WORD_BITS-1:0]                      onehot;
   logic [bba_pkg::BIT_BITS-1:0]                       low_index;
   logic [bba_pkg::ADDR_BITS+bba_pkg::BIT_BITS-1:0]    base;

   always_comb begin
      eff  = valid ? word : '0;
      base = {addr, {bba_pkg::BIT_BITS{1'b0}}};
      for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
         mask[b] = ((bba_pkg::COUNT_BITS + 1)'(base) + (bba_pkg::COUNT_BITS + 1)'(b))
                   < (bba_pkg::COUNT_BITS + 1)'(lim);
      end
      free      = ~eff & mask;
      onehot    = free & (~free + bba_pkg::WORD_BITS'(1));
      low_index = '0;
      for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
         if (onehot[b]) begin
            low_index = low_index | bba_pkg::BIT_BITS'(b);
         end
      end
      result.eff_word   = eff;
      result.free       = free;
      result.any        = |free;
      result.low_onehot = onehot;
      result.low_index  = low_index;
      result.zeros      = (bba_pkg::BIT_BITS + 1)'($countones(free));
   end

endmodule

>>> sv/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Keeps a one-bit-per-block usage map in a RAM and a running free count.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: req_tuser carries the function code
// (allocate, mark, query) and req_tdata the block index used by a mark.
// Every request yields one transaction on the rsp_ stream with the allocated
// index, the found flag and the free count after the request.
// A query needs no access to the map. A mark does one RAM read and a
// write back. An allocation scans the map one word per cycle through the
// RAM read port and stops at the first word holding a free block, or
// after the last word in the total when no block is free.
// One request is in work at a time; the next is accepted as soon as the
// previous one has its result registered, even while that result waits.
// When the receiver stalls, the result is held and a finished request waits
// for the output register before the block returns to idle.
// At reset every block is free and the total is 4096. A write on the csr_
// port sets the total and starts a recount of the map, one word per cycle,
// during which no request is accepted.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [11:0] block_index
   input  logic [bba_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] func
   input  logic [bba_pkg::FUNC_BITS-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [11:0] allocated_index, [24:12] free_count
   output logic [bba_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] found
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic [bba_pkg::TOTAL_BITS-1:0]    csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_DONE,
      ST_RECOUNT
   } state_type;

   state_type                          state_ff, state_in;
   logic [bba_pkg::TOTAL_BITS-1:0]     total_ff, total_in;
   logic [bba_pkg::COUNT_BITS-1:0]     free_ff, free_in;
   logic [bba_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [bba_pkg::MAP_WORDS-1:0]      valid_ff, valid_in;
   logic [bba_pkg::ADDR_BITS:0]        issue_ff, issue_in;
   logic                               pend_ff, pend_in;
   logic [bba_pkg::ADDR_BITS-1:0]      pend_addr_ff, pend_addr_in;
   logic [bba_pkg::BIT_BITS-1:0]       bit_ff, bit_in;
   logic [bba_pkg::INDEX_BITS-1:0]     res_index_ff, res_index_in;
   logic                               res_found_ff, res_found_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::INDEX_BITS-1:0]     rsp_index_ff, rsp_index_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [bba_pkg::COUNT_BITS-1:0]     rsp_free_ff, rsp_free_in;

   logic [bba_pkg::COUNT_BITS-1:0]     lim;
   logic [bba_pkg::ADDR_BITS:0]        nwords;
   logic [bba_pkg::INDEX_BITS-1:0]     req_index;
   bba_pkg::func_type                  req_func;
   bba_pkg::word_eval_type             ev;

   logic                               ram_wr_en;
   logic [bba_pkg::ADDR_BITS-1:0]      ram_wr_addr;
   logic [bba_pkg::WORD_BITS-1:0]      ram_wr_data;
   logic                               ram_rd_en;
   logic [bba_pkg::ADDR_BITS-1:0]      ram_rd_addr;
   logic [bba_pkg::WORD_BITS-1:0]      ram_rd_data;

   assign lim = (bba_pkg::COUNT_BITS + 1)'(total_ff) > (bba_pkg::COUNT_BITS + 1)'(bba_pkg::MAX_BLOCKS)
                ? bba_pkg::COUNT_BITS'(bba_pkg::MAX_BLOCKS)
                : bba_pkg::COUNT_BITS'(total_ff);
   assign nwords = (bba_pkg::ADDR_BITS + 1)'(((bba_pkg::COUNT_BITS + 1)'(lim)
                   + (bba_pkg::COUNT_BITS + 1)'(bba_pkg::WORD_BITS - 1)) >> bba_pkg::BIT_BITS);
   assign req_index  = req_tdata[bba_pkg::INDEX_BITS-1:0];
   assign req_func   = bba_pkg::func_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);

   bba_ram #(
      .WIDTH(bba_pkg::WORD_BITS),
      .DEPTH(bba_pkg::MAP_WORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   bba_word_eval u_eval (
      .word  (ram_rd_data),
      .valid (valid_ff[pend_addr_ff]),
      .addr  (pend_addr_ff),
      .lim   (lim),
      .result(ev)
   );

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      bit_in       = bit_ff;
      res_index_in = res_index_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      rsp_free_in  = rsp_free_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = ev.eff_word | ev.low_onehot;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_ff[bba_pkg::ADDR_BITS-1:0];

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_index_in = '0;
               res_found_in = 1'b0;
               case (req_func)
                  bba_pkg::FUNC_ALLOC: begin
                     issue_in = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  bba_pkg::FUNC_MARK: begin
                     if (bba_pkg::COUNT_BITS'(req_index) < lim) begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = bba_pkg::ADDR_BITS'(
                                          req_index[bba_pkg::INDEX_BITS-1:bba_pkg::BIT_BITS]);
                        pend_addr_in = ram_rd_addr;
                        bit_in       = req_index[bba_pkg::BIT_BITS-1:0];
                        state_in     = ST_MARK;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < nwords) begin
               ram_rd_en    = 1'b1;
               issue_in     = issue_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[bba_pkg::ADDR_BITS-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && ev.any) begin
               ram_wr_en              = 1'b1;
               valid_in[pend_addr_ff] = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - 1'b1;
               end
               res_index_in = bba_pkg::INDEX_BITS'({pend_addr_ff, ev.low_index});
               res_found_in = 1'b1;
               state_in     = ST_DONE;
            end else if (!pend_ff && issue_ff >= nwords) begin
               state_in = ST_DONE;
            end
         end
         ST_MARK: begin
            ram_wr_data = ev.eff_word | (bba_pkg::WORD_BITS'(1) << bit_ff);
            if (ev.free[bit_ff]) begin
               ram_wr_en              = 1'b1;
               valid_in[pend_addr_ff] = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_index_ff;
               rsp_found_in = res_found_ff;
               rsp_free_in  = free_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_RECOUNT: begin
            if (issue_ff < nwords) begin
               ram_rd_en    = 1'b1;
               issue_in     = issue_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[bba_pkg::ADDR_BITS-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               count_in = count_ff + bba_pkg::COUNT_BITS'(ev.zeros);
            end else if (issue_ff >= nwords) begin
               free_in  = count_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         total_in = csr_wr_data;
         issue_in = '0;
         pend_in  = 1'b0;
         count_in = '0;
         state_in = ST_RECOUNT;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      bit_ff       <= bit_in;
      res_index_ff <= res_index_in;
      res_found_ff <= res_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_free_ff  <= rsp_free_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= bba_pkg::TOTAL_BITS'(bba_pkg::TOTAL_RESET);
         free_ff      <= bba_pkg::COUNT_BITS'(bba_pkg::FREE_RESET);
         count_ff     <= '0;
         valid_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bba_pkg::RSP_DATA_BITS'({rsp_free_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_found_ff;

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_index_ff == '0))
      else $error("Result without an allocation carries a nonzero index.");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (pend_ff || state_ff == ST_MARK)
                    && (state_ff == ST_SCAN || state_ff == ST_MARK))
      else $error("Map written outside an allocate or mark update.");

   a_free_within_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RECOUNT) |-> (free_ff <= lim))
      else $error("Free count exceeds the block total.");

   a_hit_reports_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && pend_ff && ev.any && !csr_wr_en)
      |=> (state_ff == ST_DONE && res_found_ff))
      else $error("Free block found but the result is not marked found.");

endmodule
